// File: rtl/lnr_pkg.sv
// shared constants, types and divider request and response structs for the layer normalization row core
package lnr_pkg;

    localparam int ROW_LEN = 64;
    localparam int ADDR_W  = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;
    localparam int CNT_W   = $clog2(ROW_LEN + 1);

    localparam int DATA_W  = 16;
    localparam int SUM_W   = DATA_W + CNT_W - 1;
    localparam int S2_W    = 2 * DATA_W - 1 + CNT_W;
    localparam int MEM_W   = 3 * DATA_W;

    localparam int DIV_NW  = 63;
    localparam int DIV_DW  = CNT_W + S2_W;
    localparam int DIV_CW  = $clog2(DIV_NW + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_APPLY_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_APPLY_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON      = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } lnr_div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } lnr_div_rsp_t;

endpackage

// File: rtl/layer_normalization_row_core.sv
// layer normalization over one row: element buffer, statistics, rstd and result emission
// Items of a row are taken one per cycle and stored in a 64-entry buffer memory while the
// running sum is kept. The item marked row_end closes the row (items past 64 are dropped and
// every result of that row carries row_overflow). After row_end the buffer is read again to
// form the sum of squares; the variance and 2^62 / (variance + epsilon) each take one pass
// of the shared divider (63 steps), and the square root is formed one result bit per step.
// Each result then needs one buffer read and one more divider pass by n; results are formed
// one at a time and wait in ST_EOUT for a free result register. Input is not accepted
// while a row is being worked off; the result register lets the last result wait for the
// consumer while the next row loads. Configuration may be written whenever the block is idle.
module layer_normalization_row_core import lnr_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_x_value,
    input  logic signed [DATA_W-1:0] s_gamma_value,
    input  logic signed [DATA_W-1:0] s_beta_value,
    input  logic                     s_row_end,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_y_value,
    output logic                     m_last_out,
    output logic                     m_row_overflow
);

    localparam int D_W    = CNT_W + DATA_W + 1;
    localparam int R_W    = 32;
    localparam int PROD_W = D_W + R_W + 1;
    localparam int TQ_W   = PROD_W + 1 - 15;
    localparam int P_W    = 32 + DATA_W;
    localparam int Y_W    = 34;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_VMUL, ST_VSUB, ST_VWAIT, ST_RWAIT, ST_SQRT,
        ST_ERD, ST_EDAT, ST_EMUL, ST_EDIV, ST_EWAIT, ST_ESCL, ST_EOUT
    } state_t;

    state_t state_reg;

    logic              apply_scale_reg;
    logic              apply_offset_reg;
    logic [DATA_W-1:0] epsilon_reg;

    logic [MEM_W-1:0] buf_mem [ROW_LEN];
    logic [MEM_W-1:0] rdata_reg;
    logic             mem_we;

    logic [CNT_W-1:0]        elem_count_reg;
    logic signed [SUM_W-1:0] running_sum_reg;
    logic                    dropped_reg;
    logic [CNT_W-1:0]        idx_reg;

    logic              rd_v_reg;
    logic              sq_v_reg;
    logic [30:0]       sq_reg;
    logic [S2_W-1:0]   s2_reg;
    logic [DIV_DW-1:0] ns2_reg;
    logic [2*SUM_W-1:0] s1sq_reg;
    logic [2*CNT_W-1:0] nn_reg;

    logic [DIV_NW-1:0] sv_reg;
    logic [DIV_NW-1:0] res_reg;
    logic [DIV_NW-1:0] bit_reg;

    logic signed [D_W-1:0]    d_reg;
    logic signed [DATA_W-1:0] g_reg;
    logic signed [DATA_W-1:0] b_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic signed [31:0]       z_reg;
    logic signed [P_W-1:0]    p_reg;

    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_y_value_reg;
    logic                     m_last_out_reg;
    logic                     m_row_overflow_reg;

    lnr_div_req_t div_req_reg;
    lnr_div_rsp_t div_rsp;

    logic                     s_acc;
    logic                     out_load;
    logic                     issue;
    logic signed [DATA_W-1:0] rd_x;
    logic signed [31:0]       sq_full;
    logic [32:0]              vsum;
    logic [DIV_NW-1:0]        sum_rb;
    logic signed [PROD_W:0]   tt;
    logic signed [TQ_W-1:0]   tq;
    logic signed [TQ_W:0]     mag;
    logic                     q_big;
    logic signed [Y_W-1:0]    y_rnd;
    logic signed [Y_W-1:0]    y_sum;
    logic signed [DATA_W-1:0] y_sat;
    logic                     is_last;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign mem_we  = s_acc && (elem_count_reg < CNT_W'(ROW_LEN));
    assign issue   = (idx_reg < elem_count_reg);
    assign rd_x    = $signed(rdata_reg[MEM_W-1 -: DATA_W]);
    assign is_last = ((idx_reg + 1'b1) == elem_count_reg);
    assign out_load = (state_reg == ST_EOUT) && (!m_valid_reg || m_ready);

    lnr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req_reg),
        .rsp     (div_rsp)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            apply_scale_reg  <= 1'b0;
            apply_offset_reg <= 1'b0;
            epsilon_reg      <= DATA_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_APPLY_SCALE:  apply_scale_reg  <= cfg_wdata[0];
                CFG_APPLY_OFFSET: apply_offset_reg <= cfg_wdata[0];
                CFG_EPSILON:      epsilon_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // element buffer: x, gamma, beta per entry
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            buf_mem[elem_count_reg[ADDR_W-1:0]] <= {s_x_value, s_gamma_value, s_beta_value};
        end
        rdata_reg <= buf_mem[idx_reg[ADDR_W-1:0]];
    end

    always_comb begin
        sq_full = rd_x * rd_x;
        vsum    = {1'b0, div_rsp.quotient[31:0]} + 33'(epsilon_reg);
        if (vsum == '0) begin
            vsum = 33'd1;
        end
        sum_rb  = res_reg + bit_reg;
        tt      = (PROD_W+1)'(prod_reg) + $signed({1'b0, elem_count_reg, 14'd0});
        tq      = TQ_W'(tt >>> 15);
        // floor division of a negative value goes through its magnitude rounded up
        if (tq < 0) begin
            mag = -(TQ_W+1)'(tq) + $signed((TQ_W+1)'(elem_count_reg)) - 1;
        end else begin
            mag = (TQ_W+1)'(tq);
        end
        q_big = |div_rsp.quotient[DIV_NW-1:31];
        if (apply_scale_reg) begin
            y_rnd = Y_W'((p_reg + P_W'(32768)) >>> 16);
        end else begin
            y_rnd = Y_W'(($signed({z_reg[31], z_reg}) + 33'sd128) >>> 8);
        end
        y_sum = y_rnd + (apply_offset_reg ? Y_W'(b_reg) : Y_W'(0));
        if (y_sum > Y_W'(32767)) begin
            y_sat = 16'sh7fff;
        end else if (y_sum < -Y_W'(32768)) begin
            y_sat = -16'sh8000;
        end else begin
            y_sat = DATA_W'(y_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            elem_count_reg    <= '0;
            running_sum_reg   <= '0;
            dropped_reg       <= 1'b0;
            idx_reg           <= '0;
            rd_v_reg          <= 1'b0;
            sq_v_reg          <= 1'b0;
            m_valid_reg       <= 1'b0;
            div_req_reg.start <= 1'b0;
        end else begin
            // divider starts on the cycle after each request state
            div_req_reg.start <= (state_reg == ST_VSUB) || (state_reg == ST_EDIV)
                                 || ((state_reg == ST_VWAIT) && div_rsp.done);
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        if (mem_we) begin
                            running_sum_reg <= running_sum_reg + SUM_W'(s_x_value);
                            elem_count_reg  <= elem_count_reg + 1'b1;
                        end else begin
                            dropped_reg <= 1'b1;
                        end
                        if (s_row_end) begin
                            idx_reg   <= '0;
                            s2_reg    <= '0;
                            state_reg <= ST_SQ;
                        end
                    end
                end
                ST_SQ: begin
                    // read, square, accumulate as a three-deep pipe
                    if (issue) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    rd_v_reg <= issue;
                    sq_v_reg <= rd_v_reg;
                    sq_reg   <= sq_full[30:0];
                    if (sq_v_reg) begin
                        s2_reg <= s2_reg + S2_W'(sq_reg);
                    end
                    if (!issue && !rd_v_reg && !sq_v_reg) begin
                        state_reg <= ST_VMUL;
                    end
                end
                ST_VMUL: begin
                    ns2_reg   <= DIV_DW'(elem_count_reg * s2_reg);
                    s1sq_reg  <= (2*SUM_W)'(running_sum_reg * running_sum_reg);
                    nn_reg    <= elem_count_reg * elem_count_reg;
                    state_reg <= ST_VSUB;
                end
                ST_VSUB: begin
                    div_req_reg.dividend <= DIV_NW'(ns2_reg - DIV_DW'(s1sq_reg));
                    div_req_reg.divisor  <= DIV_DW'(nn_reg);
                    state_reg            <= ST_VWAIT;
                end
                ST_VWAIT: begin
                    if (div_rsp.done) begin
                        div_req_reg.dividend <= {1'b1, {(DIV_NW-1){1'b0}}};
                        div_req_reg.divisor  <= DIV_DW'(vsum);
                        state_reg            <= ST_RWAIT;
                    end
                end
                ST_RWAIT: begin
                    if (div_rsp.done) begin
                        sv_reg    <= div_rsp.quotient;
                        res_reg   <= '0;
                        bit_reg   <= {1'b1, {(DIV_NW-1){1'b0}}};
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (sv_reg >= sum_rb) begin
                        sv_reg  <= sv_reg - sum_rb;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0]) begin
                        idx_reg   <= '0;
                        state_reg <= ST_ERD;
                    end
                end
                ST_ERD: begin
                    state_reg <= ST_EDAT;
                end
                ST_EDAT: begin
                    d_reg     <= D_W'($signed({1'b0, elem_count_reg}) * rd_x)
                                 - D_W'(running_sum_reg);
                    g_reg     <= $signed(rdata_reg[2*DATA_W-1 -: DATA_W]);
                    b_reg     <= $signed(rdata_reg[DATA_W-1:0]);
                    state_reg <= ST_EMUL;
                end
                ST_EMUL: begin
                    prod_reg  <= PROD_W'(d_reg * $signed({1'b0, res_reg[R_W-1:0]}));
                    state_reg <= ST_EDIV;
                end
                ST_EDIV: begin
                    neg_reg              <= (tq < 0);
                    div_req_reg.dividend <= DIV_NW'(unsigned'(mag));
                    div_req_reg.divisor  <= DIV_DW'(elem_count_reg);
                    state_reg            <= ST_EWAIT;
                end
                ST_EWAIT: begin
                    if (div_rsp.done) begin
                        // clamp to 32 bits
                        if (neg_reg) begin
                            z_reg <= q_big ? 32'sh8000_0000 : -$signed(div_rsp.quotient[31:0]);
                        end else begin
                            z_reg <= q_big ? 32'sh7fff_ffff : $signed(div_rsp.quotient[31:0]);
                        end
                        state_reg <= ST_ESCL;
                    end
                end
                ST_ESCL: begin
                    p_reg     <= z_reg * g_reg;
                    state_reg <= ST_EOUT;
                end
                ST_EOUT: begin
                    if (out_load) begin
                        m_valid_reg        <= 1'b1;
                        m_y_value_reg      <= y_sat;
                        m_last_out_reg     <= is_last;
                        m_row_overflow_reg <= dropped_reg;
                        if (is_last) begin
                            elem_count_reg  <= '0;
                            running_sum_reg <= '0;
                            dropped_reg     <= 1'b0;
                            state_reg       <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_ERD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_y_value      = m_y_value_reg;
    assign m_last_out     = m_last_out_reg;
    assign m_row_overflow = m_row_overflow_reg;

`ifndef SYNTHESIS
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req_reg.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        elem_count_reg <= CNT_W'(ROW_LEN))
        else $error("element count past row length");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && is_last) |=> (elem_count_reg == '0) && s_ready)
        else $error("row state not cleared after final item");

    a_no_load_over: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && m_valid_reg) |-> m_ready)
        else $error("result register overwritten");
`endif

endmodule

// File: rtl/lnr_div.sv
// restoring unsigned divider, one quotient bit per cycle
module lnr_div import lnr_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  lnr_div_req_t req,
    output lnr_div_rsp_t rsp
);

    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] dvs_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_DW:0]   shifted;
    logic              ge;
    logic [DIV_DW-1:0] rem_next;
    logic [DIV_NW-1:0] quo_next;

    always_comb begin
        shifted  = {rem_reg, quo_reg[DIV_NW-1]};
        ge       = (shifted >= {1'b0, dvs_reg});
        rem_next = ge ? DIV_DW'(shifted - {1'b0, dvs_reg}) : DIV_DW'(shifted);
        quo_next = {quo_reg[DIV_NW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: tb/tb_layer_normalization_row_core.sv
// testbench for the layer normalization row core: row stimulus, predictor and result check
`timescale 1ns / 1ps

module tb_layer_normalization_row_core import lnr_pkg::*; ();

    typedef struct {
        logic signed [15:0] y;
        logic               last;
        logic               ovf;
    } norm_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [DATA_W-1:0] s_x_value = '0;
    logic signed [DATA_W-1:0] s_gamma_value = '0;
    logic signed [DATA_W-1:0] s_beta_value = '0;
    logic s_row_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_y_value;
    logic m_last_out;
    logic m_row_overflow;

    layer_normalization_row_core dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic signed [15:0] row_x[ROW_LEN];
    logic signed [15:0] row_g[ROW_LEN];
    logic signed [15:0] row_b[ROW_LEN];
    int unsigned row_cnt;
    longint row_sum;
    bit row_dropped;
    bit scale_en;
    bit offset_en;
    longint unsigned eps_val;

    norm_result_t expected_q[$];
    int err_cnt;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int quiet_cycles;
    bit done_flag;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        err_cnt++;
    endtask

    function automatic longint round_div(input longint num, input longint den);
        longint t;
        t = num + den / 2;
        if (t >= 0) return t / den;
        return -((-t + den - 1) / den);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    task automatic normalize_row(input logic signed [15:0] x, input logic signed [15:0] g,
                                 input logic signed [15:0] b, input bit last);
        longint n, s2, var0, d, z, y;
        longint unsigned v, r;
        norm_result_t res;
        if (row_cnt < ROW_LEN) begin
            row_x[row_cnt] = x;
            row_g[row_cnt] = g;
            row_b[row_cnt] = b;
            row_sum += x;
            row_cnt++;
        end else begin
            row_dropped = 1;
        end
        if (!last) return;
        n = row_cnt;
        s2 = 0;
        for (int i = 0; i < row_cnt; i++) s2 += longint'(row_x[i]) * row_x[i];
        var0 = (n * s2 - row_sum * row_sum) / (n * n);
        v = longint'(var0) + eps_val;
        if (v == 0) v = 1;
        r = int_sqrt((64'd1 << 62) / v);
        for (int i = 0; i < row_cnt; i++) begin
            d = n * row_x[i] - row_sum;
            z = round_div(d * longint'(r), n * 32768);
            if (z > 64'sd2147483647) z = 64'sd2147483647;
            if (z < -64'sd2147483648) z = -64'sd2147483648;
            if (scale_en) y = round_div(z * row_g[i], 65536);
            else y = round_div(z, 256);
            if (offset_en) y += row_b[i];
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            res.y = y[15:0];
            res.last = (i + 1 == row_cnt);
            res.ovf = row_dropped;
            expected_q = {expected_q, res};
        end
        row_cnt = 0;
        row_sum = 0;
        row_dropped = 0;
    endtask

    // valid stays high after an item until the next call offers a new one or idles
    task automatic send_element(input logic signed [15:0] x, input logic signed [15:0] g,
                                input logic signed [15:0] b, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_x_value <= x;
        s_gamma_value <= g;
        s_beta_value <= b;
        s_row_end <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        normalize_row(x, g, b, last);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_APPLY_SCALE: scale_en = val[0];
            CFG_APPLY_OFFSET: offset_en = val[0];
            CFG_EPSILON: eps_val = 64'(val);
            default: ;
        endcase
    endtask

    task automatic set_config(input bit sc, input bit of, input logic [15:0] e);
        wait_drained();
        write_reg(CFG_APPLY_SCALE, {15'd0, sc});
        write_reg(CFG_APPLY_OFFSET, {15'd0, of});
        write_reg(CFG_EPSILON, e);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_row(input int len);
        for (int i = 0; i < len; i++)
            send_element(16'($urandom), 16'($urandom), 16'($urandom), i == len - 1);
    endtask

    task automatic test_extremes();
        send_element(16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
        send_element(-16'sh8000, -16'sh8000, -16'sh8000, 1);
        send_element(16'sh0100, 16'sh0100, 16'sh0000, 1);
        send_element(16'sh0000, 16'sh7fff, -16'sh8000, 0);
        send_element(16'sh0001, -16'sh0001, 16'sh0001, 0);
        send_element(-16'sh0001, 16'sh0200, 16'sh0000, 1);
    endtask

    task automatic test_zero_variance();
        // constant row with zero epsilon forces the zero-denominator path
        set_config(1, 1, 16'd0);
        for (int i = 0; i < 4; i++) send_element(16'sh0123, 16'sh0100, 16'sh0050, i == 3);
        send_element(-16'sh8000, 16'sh7fff, 16'sh7fff, 1);
    endtask

    task automatic test_overflow_row();
        // 66 elements: the last two are dropped
        set_config(1, 0, 16'hffff);
        send_random_row(ROW_LEN + 2);
    endtask

    task automatic test_random_rows(input int total);
        int sent, len;
        sent = 0;
        while (sent < total) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(ROW_LEN, 1) : $urandom_range(6, 1);
            send_random_row(len);
            sent += len;
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_cycles = 400;
        send_random_row(3);
        send_random_row(3);
        send_random_row(2);
        // sender waits for the block to empty
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_q.size() != 0);
        send_random_row(2);
    endtask

    // result check
    always @(posedge aclk) begin
        norm_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected item");
            end else begin
                e = expected_q.pop_front();
                if (m_y_value !== e.y)
                    report_mismatch($sformatf("y %0d exp %0d", m_y_value, e.y));
                if (m_last_out !== e.last)
                    report_mismatch($sformatf("last %0b exp %0b", m_last_out, e.last));
                if (m_row_overflow !== e.ovf)
                    report_mismatch($sformatf("ovf %0b exp %0b", m_row_overflow, e.ovf));
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000 && !done_flag) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        err_cnt = 0;
        quiet_cycles = 0;
        hold_cycles = 0;
        done_flag = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        row_cnt = 0;
        row_sum = 0;
        row_dropped = 0;
        scale_en = 0;
        offset_en = 0;
        eps_val = 1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        set_config(1, 1, 16'd1);
        test_extremes();
        test_zero_variance();
        test_overflow_row();
        send_idle_pct = 56;
        set_config(0, 1, 16'd256);
        test_random_rows(8);
        recv_stall_pct = 56;
        send_idle_pct = 0;
        set_config(1, 0, 16'd0);
        test_random_rows(8);
        send_idle_pct = 29;
        recv_stall_pct = 29;
        set_config(1, 1, 16'hffff);
        test_random_rows(8);
        recv_stall_pct = 0;
        test_backpressure();
        send_idle_pct = 0;
        set_config(0, 0, 16'd1);
        test_random_rows(8);
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        done_flag = 1;
        repeat (300) @(posedge aclk);
        if (err_cnt == 0 && expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/lnr_pkg.sv
rtl/lnr_div.sv
rtl/layer_normalization_row_core.sv
tb/tb_layer_normalization_row_core.sv
